// File: rtl/r2fft_pkg.sv
package r2fft_pkg;

	localparam int POINTS     = 1024;
	localparam int LG_POINTS  = $clog2(POINTS);
	localparam int SAMPLE_W   = 16;
	localparam int RES_W      = 26;
	localparam int TW_W       = 17;
	localparam int ENTRY_W    = 2 * RES_W;
	localparam int ADDR_W     = LG_POINTS;
	localparam int TW_DEPTH   = POINTS / 2;
	localparam int TWA_W      = LG_POINTS - 1;
	localparam int STG_W      = $clog2(LG_POINTS + 1);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef struct packed {
		logic                       cmd;
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
	} req_t;

	localparam int REQ_W = 1 + 2 * SAMPLE_W;

	localparam logic [63:0] PI_Q40 = 64'h3243F6A8886;

	// Unsigned quotient by shift and subtract (elaboration only).
	function automatic longint unsigned udiv_small(input longint unsigned num,
			input longint unsigned den);
		longint unsigned rem, quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Q15 sine or cosine of 2*pi*k/POINTS for k <= POINTS/8 (elaboration only).
	function automatic longint taylor_q15(input longint k, input bit odd);
		longint unsigned x, x2, term, d;
		longint sum;
		longint unsigned lp;
		lp = longint'(POINTS);
		x = (64'd2 * longint'(k) * PI_Q40 + lp * 64'd512) >> (LG_POINTS + 10);
		x2 = (x * x) >> 30;
		term = odd ? x : (64'd1 << 30);
		sum = longint'(term);
		for (int n = 1; n <= 7; n++) begin
			d = odd ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
			term = udiv_small((term * x2) >> 30, d);
			if (n % 2 == 1) sum = sum - longint'(term);
			else            sum = sum + longint'(term);
		end
		return (sum + 16384) >>> 15;
	endfunction

	function automatic logic [2*TW_W-1:0] twiddle(input int r);
		longint s, c;
		int k, j;
		k = (r <= POINTS / 4) ? r : POINTS / 2 - r;
		if (k <= POINTS / 8) begin
			s = taylor_q15(k, 1'b1);
			c = taylor_q15(k, 1'b0);
		end else begin
			j = POINTS / 4 - k;
			s = taylor_q15(j, 1'b0);
			c = taylor_q15(j, 1'b1);
		end
		if (r > POINTS / 4) c = -c;
		return {TW_W'(c), TW_W'(s)};
	endfunction

	function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] v);
		logic [ADDR_W-1:0] o;
		for (int b = 0; b < ADDR_W; b++) o[b] = v[ADDR_W-1-b];
		return o;
	endfunction

	function automatic logic signed [RES_W-1:0] sat_res(input logic signed [RES_W+1:0] v);
		if (v > (RES_W+2)'(2**(RES_W-1) - 1)) return {1'b0, {(RES_W-1){1'b1}}};
		if (v < -(RES_W+2)'(2**(RES_W-1)))   return {1'b1, {(RES_W-1){1'b0}}};
		return v[RES_W-1:0];
	endfunction

endpackage

// File: rtl/r2fft_ram.sv
module r2fft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/r2fft_front.sv
module r2fft_front import r2fft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             full,
	output logic             busy,
	output logic             push,
	output logic [REQ_W-1:0] push_data,
	input  logic             command,
	input  logic [SAMPLE_W-1:0] sample_real,
	input  logic [SAMPLE_W-1:0] sample_imag
);
	// Queue nearly full or a previous request in flight holds the front off.
	logic hold_q;
	req_t rq;

	assign busy = full | hold_q;
	assign push = start & ~busy;
	assign rq.cmd = command;
	assign rq.re  = sample_real;
	assign rq.im  = sample_imag;
	assign push_data = rq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else begin
			hold_q <= push;
		end
	end
endmodule

// File: rtl/r2fft_queue.sv
module r2fft_queue import r2fft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [REQ_W-1:0] wdata,
	input  logic             pop,
	output logic [REQ_W-1:0] rdata,
	output logic             empty,
	output logic             full
);
	logic [REQ_W-1:0]  slot_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	// Two slots of margin cover the front's registered hold.
	assign full  = (cnt_q >= (QPTR_W+1)'(QDEPTH - 2));
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end
endmodule

// File: rtl/r2fft_back.sv
module r2fft_back import r2fft_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    inv_cfg,
	input  logic                    q_empty,
	input  logic [REQ_W-1:0]        q_data,
	output logic                    q_pop,
	output logic                    res_valid,
	output logic signed [RES_W-1:0] res_re,
	output logic signed [RES_W-1:0] res_im,
	output logic [ADDR_W-1:0]       res_idx,
	output logic                    res_rdy
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BFA   = 4'd1; // read a
	localparam logic [3:0] ST_BFB   = 4'd2; // read b
	localparam logic [3:0] ST_MUL   = 4'd3; // products
	localparam logic [3:0] ST_SUM   = 4'd4; // rounding
	localparam logic [3:0] ST_WRA   = 4'd5; // write a
	localparam logic [3:0] ST_WRB   = 4'd6; // write b
	localparam logic [3:0] ST_FRD   = 4'd7; // fetch read issued
	localparam logic [3:0] ST_FOUT  = 4'd8; // fetch data out
	localparam logic [3:0] ST_BFW   = 4'd9; // b data arrives

	logic [3:0]        st_q;
	logic [ADDR_W:0]   load_q;
	logic [ADDR_W-1:0] rd_cnt_q;
	logic              done_q, inv_q;
	logic [STG_W-1:0]  stage_q;
	logic [ADDR_W-2:0] bf_q;

	req_t rq;
	assign rq = q_data;

	// Butterfly addressing: stage m (1-based) has half = 2^(m-1).
	logic [ADDR_W-1:0] half, addr_a, addr_b, jmask;
	logic [ADDR_W-1:0] bf_ext, jj, gg;
	logic [TWA_W-1:0]  tw_idx;
	always_comb begin
		half   = ADDR_W'(1) << (stage_q - 1'b1);
		jmask  = half - 1'b1;
		bf_ext = {1'b0, bf_q};
		jj     = bf_ext & jmask;
		gg     = (bf_ext & ~jmask) << 1;
		addr_a = gg | jj;
		addr_b = addr_a | half;
		tw_idx = TWA_W'(jj << (ADDR_W - stage_q));
	end

	// Twiddle table is a constant ROM.
	logic [2*TW_W-1:0] tw_rom [TW_DEPTH];
	always_comb begin
		for (int r = 0; r < TW_DEPTH; r++) tw_rom[r] = twiddle(r);
	end

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_wa, ram_ra;
	logic [ENTRY_W-1:0]    ram_wd, ram_rd;

	r2fft_ram #(.WIDTH(ENTRY_W), .DEPTH(POINTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic signed [RES_W-1:0]   ar_q, ai_q, br_q, bi_q;
	logic signed [TW_W-1:0]    c_q, s_q;
	logic signed [RES_W+TW_W:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [RES_W+1:0]   tr_q, ti_q;
	logic signed [RES_W+TW_W+1:0] sr, si;
	logic [ADDR_W-1:0] pa_q, pb_q;

	always_comb begin
		sr = (RES_W+TW_W+2)'(p1_q) + (RES_W+TW_W+2)'(p2_q) + (RES_W+TW_W+2)'(16384);
		si = (RES_W+TW_W+2)'(p3_q) - (RES_W+TW_W+2)'(p4_q) + (RES_W+TW_W+2)'(16384);
	end

	// Inverse output post-processing on the fetched entry.
	logic signed [RES_W-1:0] f_re, f_im;
	logic signed [RES_W+1:0] f_imn;
	always_comb begin
		f_re  = ram_rd[ENTRY_W-1:RES_W];
		f_im  = ram_rd[RES_W-1:0];
		f_imn = -(RES_W+2)'(f_im);
	end

	// Samples enter at bit-reversed addresses as they are. In inverse mode the
	// first stage conjugates every entry as it reads it, since that stage touches
	// each entry exactly once.
	logic signed [RES_W-1:0] ld_re, ld_im;
	always_comb begin
		ld_re = RES_W'(rq.re);
		ld_im = RES_W'(rq.im);
	end

	logic conj_rd;
	assign conj_rd = inv_q && (stage_q == STG_W'(1));

	logic is_last_bf;
	assign is_last_bf = (bf_q == '1);

	always_comb begin
		q_pop  = 1'b0;
		ram_we = 1'b0;
		ram_wa = pa_q;
		ram_wd = {ar_q, ai_q};
		ram_ra = addr_a;
		unique case (st_q)
			ST_IDLE: begin
				q_pop = ~q_empty;
				if (~q_empty && rq.cmd == CMD_PUSH && !done_q) begin
					ram_we = 1'b1;
					ram_wa = bitrev(load_q[ADDR_W-1:0]);
					ram_wd = {ld_re, ld_im};
				end
				ram_ra = rd_cnt_q;
			end
			ST_BFA: ram_ra = addr_a;
			ST_BFB: ram_ra = addr_b;
			ST_WRA: begin
				ram_we = 1'b1;
				ram_wa = pa_q;
				ram_wd = {sat_res((RES_W+2)'(ar_q) + tr_q), sat_res((RES_W+2)'(ai_q) + ti_q)};
			end
			ST_WRB: begin
				ram_we = 1'b1;
				ram_wa = pb_q;
				ram_wd = {sat_res((RES_W+2)'(ar_q) - tr_q), sat_res((RES_W+2)'(ai_q) - ti_q)};
			end
			default: ram_ra = rd_cnt_q;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_BFA: begin
				pa_q <= addr_a;
				pb_q <= addr_b;
				{c_q, s_q} <= tw_rom[tw_idx];
			end
			ST_BFB: begin
				ar_q <= ram_rd[ENTRY_W-1:RES_W];
				ai_q <= conj_rd ? -ram_rd[RES_W-1:0] : ram_rd[RES_W-1:0];
			end
			ST_BFW: begin
				br_q <= ram_rd[ENTRY_W-1:RES_W];
				bi_q <= conj_rd ? -ram_rd[RES_W-1:0] : ram_rd[RES_W-1:0];
			end
			ST_MUL: begin
				p1_q <= br_q * c_q;
				p2_q <= bi_q * s_q;
				p3_q <= bi_q * c_q;
				p4_q <= br_q * s_q;
			end
			ST_SUM: begin
				tr_q <= (RES_W+2)'(sr >>> 15);
				ti_q <= (RES_W+2)'(si >>> 15);
			end
			ST_FOUT: begin
				if (inv_q) begin
					res_re <= sat_res((RES_W+2)'(f_re >>> LG_POINTS));
					res_im <= sat_res(f_imn >>> LG_POINTS);
				end else begin
					res_re <= f_re;
					res_im <= f_im;
				end
			end
			default: ;
		endcase
		if (st_q == ST_IDLE && ~q_empty && rq.cmd == CMD_FETCH && !done_q) begin
			res_re <= '0;
			res_im <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			load_q <= '0;
			rd_cnt_q <= '0;
			done_q <= 1'b0;
			inv_q <= 1'b0;
			stage_q <= '0;
			bf_q <= '0;
			res_valid <= 1'b0;
			res_idx <= '0;
			res_rdy <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (~q_empty) begin
						if (rq.cmd == CMD_PUSH) begin
							if (!done_q) begin
								if (load_q == (ADDR_W+1)'(POINTS - 1)) begin
									load_q <= '0;
									inv_q <= inv_cfg;
									stage_q <= STG_W'(1);
									bf_q <= '0;
									st_q <= ST_BFA;
								end else begin
									load_q <= load_q + 1'b1;
								end
							end
						end else if (done_q) begin
							st_q <= ST_FRD;
						end else begin
							res_valid <= 1'b1;
							res_idx <= '0;
							res_rdy <= 1'b0;
						end
					end
				end
				ST_BFA: st_q <= ST_BFB;
				ST_BFB: st_q <= ST_BFW;
				ST_BFW: st_q <= ST_MUL;
				ST_MUL: st_q <= ST_SUM;
				ST_SUM: st_q <= ST_WRA;
				ST_WRA: st_q <= ST_WRB;
				ST_WRB: begin
					bf_q <= bf_q + 1'b1;
					st_q <= ST_BFA;
					if (is_last_bf) begin
						if (stage_q == LG_POINTS) begin
							done_q <= 1'b1;
							rd_cnt_q <= '0;
							st_q <= ST_IDLE;
						end else begin
							stage_q <= stage_q + 1'b1;
						end
					end
				end
				ST_FRD: st_q <= ST_FOUT;
				ST_FOUT: begin
					res_valid <= 1'b1;
					res_idx <= rd_cnt_q;
					res_rdy <= 1'b1;
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == '1) done_q <= 1'b0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/radix2_fft_ifft_engine_unit.sv
// Channel   | Signals                                   | Handshake
// --------- | ----------------------------------------- | -------------------------------
// request   | start, command, sample_real, sample_imag  | taken when start & !busy
// result    | done, bin_real, bin_imag, bin_index, ready_res | one-cycle strobe on done
// config    | cfg_we, cfg_wdata                         | written when cfg_we is high
//
// A push is queued and then written to the frame RAM; a fetch runs ST_FRD and ST_FOUT.
// Loading the last sample starts the transform: 512 butterflies per stage, ten stages,
// each stepping through ST_BFA, ST_BFB, ST_BFW, ST_MUL, ST_SUM, ST_WRA, ST_WRB in turn.
// Reset clears all control state; the frame RAM is not cleared and needs none, since
// a frame is transformed only after all entries are written.
// The front never takes requests back to back: busy is high in the cycle after
// each accepted request and while the request queue is near full. The receiver cannot stall.
module radix2_fft_ifft_engine_unit import r2fft_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    command,
	input  logic [SAMPLE_W-1:0]     sample_real,
	input  logic [SAMPLE_W-1:0]     sample_imag,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	output logic                    done,
	output logic signed [RES_W-1:0] bin_real,
	output logic signed [RES_W-1:0] bin_imag,
	output logic [ADDR_W-1:0]       bin_index,
	output logic                    ready_res
);
	// The inverse flag is sampled by the back end when the last sample lands.
	logic inverse_mode_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_mode_q <= 1'b0;
		end else if (cfg_we) begin
			inverse_mode_q <= cfg_wdata;
		end
	end

	logic             q_push, q_pop, q_empty, q_full;
	logic [REQ_W-1:0] q_wdata, q_rdata;

	// The front end registers nothing but its hold flag; it just frames requests.
	r2fft_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .full(q_full), .busy(busy),
		.push(q_push), .push_data(q_wdata), .command(command),
		.sample_real(sample_real), .sample_imag(sample_imag)
	);

	r2fft_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_wdata),
		.pop(q_pop), .rdata(q_rdata), .empty(q_empty), .full(q_full)
	);

	// The back end owns the frame RAM, the butterfly datapath and the read-out.
	r2fft_back u_back (
		.clk(clk), .arst_n(arst_n), .inv_cfg(inverse_mode_q),
		.q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
		.res_valid(done), .res_re(bin_real), .res_im(bin_imag),
		.res_idx(bin_index), .res_rdy(ready_res)
	);

`ifndef SYNTHESIS
	// A result that reports no frame always carries zero data.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ready_res |-> bin_real == '0 && bin_imag == '0 && bin_index == '0)
		else $error("empty fetch carries data");
	// The queue is never pushed while it is flagged full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("request queue overflow");
	// The front holds off in the cycle after every accepted request.
	a_hold_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted on consecutive cycles");
`endif
endmodule
